// ===== design/uft_pkg.sv =====
// shared constants, widths and operation codes of the unacked frame tracker
`default_nettype none

package uft_pkg;

  localparam int unsigned RING_ENTRIES      = 64;
  localparam int unsigned SUBFRAME_SLOTS    = 256;
  localparam int unsigned WINDOW_UNIT_BYTES = 1024;
  localparam int unsigned WINDOW_RESET      = 64;

  localparam int unsigned RING_AW = $clog2(RING_ENTRIES);
  localparam int unsigned RING_CW = $clog2(RING_ENTRIES + 1);
  localparam int unsigned FIFO_AW = $clog2(SUBFRAME_SLOTS);
  localparam int unsigned FIFO_CW = $clog2(SUBFRAME_SLOTS + 1);

  localparam longint unsigned MAX_BYTES = longint'(SUBFRAME_SLOTS) * 65535;
  localparam int unsigned BYTE_W  = $clog2(MAX_BYTES + 1);
  localparam int unsigned UNIT_W  = $clog2(WINDOW_UNIT_BYTES + 1);
  localparam int unsigned LIMIT_W = 16 + UNIT_W;
  localparam int unsigned CMP_W   = (LIMIT_W > BYTE_W) ? LIMIT_W : BYTE_W;
  localparam int unsigned REPLAY_W = 40;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned ACK_W    = 32;
  localparam int unsigned COPY_W   = 9;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned TRIM_W   = 24;
  localparam int unsigned FRAMES_W = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_SENT   = 3'd0,
    MODE_COPY   = 3'd1,
    MODE_ACK    = 3'd2,
    MODE_RESUME = 3'd3,
    MODE_REPLAY = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_e;

endpackage

`default_nettype wire

// ===== design/unacked_frame_tracker.sv =====
// top level: resend log accountant with entry ring, length fifo and trim sequencer
// sent, copy, replay, clear and no-op items pass through the execute and finish states, then the result is registered
// acks: the trim sequencer visits each ring entry touched and pops each length slot released
// resume acks trim one frame per pass of the same sequencer, so the cost grows with the gap
// one item at a time; the next transfer is taken in the cycle the result leaves
// reset is asynchronous and clears control state at once; the stores need no clearing pass
`default_nettype none

module unacked_frame_tracker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [uft_pkg::WIN_W-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [uft_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [uft_pkg::LEN_W-1:0]   payload_length_i,
  input  wire logic                        is_control_i,
  input  wire logic                        is_hello_i,
  input  wire logic                        last_in_frame_i,
  input  wire logic [uft_pkg::ACK_W-1:0]   ack_value_i,
  input  wire logic [uft_pkg::COPY_W-1:0]  copy_count_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             ok_o,
  output logic                             session_reset_o,
  output logic                             stalled_o,
  output logic                             unstalled_o,
  output logic [uft_pkg::TRIM_W-1:0]       released_bytes_o,
  output logic [uft_pkg::FRAMES_W-1:0]     outstanding_frames_o,
  output logic [uft_pkg::TRIM_W-1:0]       outstanding_bytes_o,
  output logic [uft_pkg::ACK_W-1:0]        last_ack_o
);

  import uft_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_TSTART = 8'b0000_0100,
    S_TREAD  = 8'b0000_1000,
    S_POP    = 8'b0001_0000,
    S_TEND   = 8'b0010_0000,
    S_RESUME = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [MODE_W-1:0] op_q;
  logic [LEN_W-1:0]  len_q;
  logic              ctrl_q, hello_q, last_q;
  logic [ACK_W-1:0]  ackv_q;
  logic [COPY_W-1:0] copy_q;

  logic [RING_AW-1:0]  ring_head_q, ring_head_d;
  logic [RING_CW-1:0]  ring_used_q, ring_used_d;
  logic [FIFO_AW-1:0]  fifo_head_q, fifo_head_d;
  logic [FIFO_CW-1:0]  fifo_used_q, fifo_used_d;
  logic [FIFO_CW-1:0]  frames_q, frames_d;
  logic [BYTE_W-1:0]   bytes_q, bytes_d;
  logic                stall_q, stall_d;
  logic [ACK_W-1:0]    serial_q, serial_d;
  logic                cur_valid_q, cur_valid_d;
  logic [RING_CW-1:0]  cur_q, cur_d;
  logic [REPLAY_W-1:0] replayed_q, replayed_d;
  logic [FIFO_CW-1:0]  pend_cnt_q, pend_cnt_d;
  logic [BYTE_W-1:0]   pend_bytes_q, pend_bytes_d;
  logic                pend_drop_q, pend_drop_d;
  logic                pend_first_q, pend_first_d;
  logic [LIMIT_W-1:0]  limit_q;

  logic [FIFO_CW-1:0]  rem_q, rem_d;
  logic [RING_CW-1:0]  off0_q, off0_d;
  logic [RING_CW-1:0]  popped_q, popped_d;
  logic [FIFO_CW-1:0]  tr_q, tr_d;
  logic [FIFO_CW-1:0]  pop_cnt_q, pop_cnt_d;
  logic                part_q, part_d;
  logic [FIFO_CW-1:0]  cnt_q, cnt_d;
  logic                rdv_q, rdv_d;

  logic                ok_q, ok_d;
  logic                rst_q, rst_d;
  logic                unst_q, unst_d;
  logic [BYTE_W-1:0]   trimmed_q, trimmed_d;

  logic                out_valid_q, out_valid_d;
  logic                out_ok_q, out_rst_q, out_stalled_q, out_unst_q;
  logic [TRIM_W-1:0]   out_trim_q, out_bytes_q;
  logic [FRAMES_W-1:0] out_frames_q;
  logic [ACK_W-1:0]    out_serial_q;

  logic                ring_we, ring_re;
  logic [RING_AW-1:0]  ring_waddr, ring_raddr;
  logic [FIFO_CW-1:0]  ring_wdata, ring_rdata;
  logic                fifo_we, fifo_re;
  logic [FIFO_AW-1:0]  fifo_waddr, fifo_raddr;
  logic [LEN_W-1:0]    fifo_wdata, fifo_rdata;

  logic in_ready;
  logic in_take;

  function automatic logic [RING_AW-1:0] ring_add(logic [RING_AW-1:0] a, logic [RING_CW-1:0] b);
    logic [RING_AW:0] s;
    s = (RING_AW+1)'(a) + (RING_AW+1)'(b);
    if (s >= (RING_AW+1)'(RING_ENTRIES)) begin
      s = s - (RING_AW+1)'(RING_ENTRIES);
    end
    return s[RING_AW-1:0];
  endfunction

  function automatic logic [FIFO_AW-1:0] fifo_add(logic [FIFO_AW-1:0] a, logic [FIFO_CW-1:0] b);
    logic [FIFO_AW:0] s;
    s = (FIFO_AW+1)'(a) + (FIFO_AW+1)'(b);
    if (s >= (FIFO_AW+1)'(SUBFRAME_SLOTS)) begin
      s = s - (FIFO_AW+1)'(SUBFRAME_SLOTS);
    end
    return s[FIFO_AW-1:0];
  endfunction

  uft_ram #(.DEPTH(RING_ENTRIES), .WIDTH(FIFO_CW)) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(ring_wdata),
    .re_i   (ring_re),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  uft_ram #(.DEPTH(SUBFRAME_SLOTS), .WIDTH(LEN_W)) u_fifo (
    .clk_i  (clk_i),
    .we_i   (fifo_we),
    .waddr_i(fifo_waddr),
    .wdata_i(fifo_wdata),
    .re_i   (fifo_re),
    .raddr_i(fifo_raddr),
    .rdata_o(fifo_rdata)
  );

  assign in_ready   = (state_q == S_IDLE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !in_ready;
  assign in_take    = in_valid_i && in_ready;

  always_comb begin
    logic              drop;
    logic [FIFO_CW-1:0] pc;
    logic [BYTE_W-1:0]  pb;
    logic [BYTE_W-1:0]  nb;
    logic              do_rst;
    logic              mid;
    logic              do_clr;
    logic              trim_go;
    logic [FIFO_CW-1:0] tc;
    logic [FIFO_CW-1:0] n;
    logic [ACK_W-1:0]   behind;
    logic [RING_CW-1:0] cur;
    logic              cv;
    logic [REPLAY_W-1:0] rep;

    state_d      = state_q;
    ring_head_d  = ring_head_q;
    ring_used_d  = ring_used_q;
    fifo_head_d  = fifo_head_q;
    fifo_used_d  = fifo_used_q;
    frames_d     = frames_q;
    bytes_d      = bytes_q;
    stall_d      = stall_q;
    serial_d     = serial_q;
    cur_valid_d  = cur_valid_q;
    cur_d        = cur_q;
    replayed_d   = replayed_q;
    pend_cnt_d   = pend_cnt_q;
    pend_bytes_d = pend_bytes_q;
    pend_drop_d  = pend_drop_q;
    pend_first_d = pend_first_q;
    rem_d        = rem_q;
    off0_d       = off0_q;
    popped_d     = popped_q;
    tr_d         = tr_q;
    pop_cnt_d    = pop_cnt_q;
    part_d       = part_q;
    cnt_d        = cnt_q;
    rdv_d        = rdv_q;
    ok_d         = ok_q;
    rst_d        = rst_q;
    unst_d       = unst_q;
    trimmed_d    = trimmed_q;

    ring_we    = 1'b0;
    ring_waddr = ring_head_q;
    ring_wdata = cnt_q;
    ring_re    = 1'b0;
    ring_raddr = ring_head_q;
    fifo_we    = 1'b0;
    fifo_waddr = fifo_add(fifo_head_q, fifo_used_q);
    fifo_wdata = len_q;
    fifo_re    = 1'b0;
    fifo_raddr = fifo_head_q;

    drop    = 1'b0;
    pc      = pend_cnt_q;
    pb      = pend_bytes_q;
    nb      = bytes_q;
    do_rst  = 1'b0;
    mid     = 1'b0;
    do_clr  = 1'b0;
    trim_go = 1'b0;
    tc      = '0;
    n       = '0;
    behind  = serial_q - ackv_q;
    cur     = cur_q;
    cv      = cur_valid_q;
    rep     = replayed_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          ok_d      = 1'b1;
          rst_d     = 1'b0;
          unst_d    = 1'b0;
          trimmed_d = '0;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        unique case (op_q)
          MODE_SENT: begin
            drop         = pend_first_q ? hello_q : pend_drop_q;
            pend_first_d = 1'b0;
            pend_drop_d  = drop;
            if (!drop && !ctrl_q) begin
              if (fifo_used_q == FIFO_CW'(SUBFRAME_SLOTS)) begin
                do_rst = 1'b1;
                mid    = !last_q;
              end else begin
                fifo_we     = 1'b1;
                fifo_used_d = fifo_used_q + 1'b1;
                pc          = pend_cnt_q + 1'b1;
                pb          = pend_bytes_q + BYTE_W'(len_q);
              end
            end
            pend_cnt_d   = pc;
            pend_bytes_d = pb;
            if (!do_rst && last_q) begin
              if (!drop && pc != '0) begin
                if (ring_used_q == RING_CW'(RING_ENTRIES)) begin
                  do_rst = 1'b1;
                end else begin
                  ring_we     = 1'b1;
                  ring_waddr  = ring_add(ring_head_q, ring_used_q);
                  ring_wdata  = pc;
                  ring_used_d = ring_used_q + 1'b1;
                  frames_d    = frames_q + pc;
                  nb          = bytes_q + pb;
                  bytes_d     = nb;
                  if (!stall_q && CMP_W'(nb) >= CMP_W'(limit_q)) begin
                    stall_d = 1'b1;
                  end
                end
              end
              pend_cnt_d   = '0;
              pend_bytes_d = '0;
              pend_drop_d  = 1'b0;
              pend_first_d = 1'b1;
            end
          end
          MODE_COPY: begin
            if (cur_valid_q && cur_q < ring_used_q) begin
              replayed_d = replayed_q + REPLAY_W'(copy_q);
              cur_d      = cur_q + 1'b1;
            end
          end
          MODE_ACK: begin
            if (cur_valid_q && REPLAY_W'(ackv_q) > replayed_q) begin
              ok_d = 1'b0;
            end else if (ackv_q > ACK_W'(frames_q)) begin
              ok_d = 1'b0;
            end else if (ackv_q != '0) begin
              trim_go = 1'b1;
              tc      = FIFO_CW'(ackv_q);
            end
          end
          MODE_RESUME: begin
            if (behind != '0 && !behind[ACK_W-1]) begin
              ok_d = 1'b0;
            end else begin
              state_d = S_RESUME;
            end
          end
          MODE_REPLAY: begin
            cur_valid_d = 1'b1;
            cur_d       = '0;
            replayed_d  = '0;
          end
          MODE_CLEAR: begin
            do_clr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_RESUME: begin
        if (serial_q == ackv_q) begin
          cur_valid_d = (ring_used_q != '0);
          cur_d       = '0;
          replayed_d  = '0;
          state_d     = S_FIN;
        end else if (frames_q == '0) begin
          ok_d    = 1'b0;
          state_d = S_FIN;
        end else begin
          trim_go = 1'b1;
          tc      = FIFO_CW'(1);
        end
      end
      S_TSTART: begin
        if (rem_q != '0 && ring_used_q != '0) begin
          ring_re = 1'b1;
          state_d = S_TREAD;
        end else begin
          state_d = S_TEND;
        end
      end
      S_TREAD: begin
        part_d    = ring_rdata > rem_q;
        n         = (ring_rdata > rem_q) ? rem_q : ring_rdata;
        cnt_d     = ring_rdata;
        pop_cnt_d = n;
        rdv_d     = 1'b0;
        if (popped_q < off0_q) begin
          tr_d = tr_q + n;
        end
        state_d = S_POP;
      end
      S_POP: begin
        if (rdv_q) begin
          // resume acks release bytes without reporting them
          if (op_q == MODE_ACK) begin
            trimmed_d = trimmed_q + BYTE_W'(fifo_rdata);
          end
          bytes_d   = (BYTE_W'(fifo_rdata) > bytes_q) ? '0 : bytes_q - BYTE_W'(fifo_rdata);
        end
        if (pop_cnt_q != '0) begin
          pop_cnt_d = pop_cnt_q - 1'b1;
          if (fifo_used_q != '0) begin
            fifo_re     = 1'b1;
            fifo_head_d = fifo_add(fifo_head_q, FIFO_CW'(1));
            fifo_used_d = fifo_used_q - 1'b1;
            rdv_d       = 1'b1;
          end else begin
            rdv_d = 1'b0;
          end
        end else if (rdv_q) begin
          rdv_d = 1'b0;
        end else begin
          // entry finished: shrink it in place or retire it
          if (part_q) begin
            ring_we    = 1'b1;
            ring_waddr = ring_head_q;
            ring_wdata = cnt_q - rem_q;
            rem_d      = '0;
          end else begin
            rem_d       = rem_q - cnt_q;
            ring_head_d = ring_add(ring_head_q, RING_CW'(1));
            ring_used_d = ring_used_q - 1'b1;
            popped_d    = popped_q + 1'b1;
          end
          state_d = S_TSTART;
        end
      end
      S_TEND: begin
        if (cv) begin
          if (cur >= popped_q) begin
            cur = cur - popped_q;
            rep = (REPLAY_W'(tr_q) > rep) ? '0 : rep - REPLAY_W'(tr_q);
          end else begin
            cur = '0;
            rep = '0;
          end
          if (cur >= ring_used_q) begin
            cv  = 1'b0;
            cur = '0;
            rep = '0;
          end
        end
        cur_valid_d = cv;
        cur_d       = cur;
        replayed_d  = rep;
        if (stall_q && CMP_W'(bytes_q) < CMP_W'(limit_q)) begin
          stall_d = 1'b0;
          if (op_q == MODE_ACK) begin
            unst_d = 1'b1;
          end
        end
        state_d = (op_q == MODE_RESUME) ? S_RESUME : S_FIN;
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (trim_go) begin
      frames_d = frames_q - tc;
      serial_d = serial_q + ACK_W'(tc);
      rem_d    = tc;
      off0_d   = cur_valid_q ? cur_q : '0;
      popped_d = '0;
      tr_d     = '0;
      state_d  = S_TSTART;
    end

    if (do_rst || do_clr) begin
      ring_head_d  = '0;
      ring_used_d  = '0;
      fifo_head_d  = '0;
      fifo_used_d  = '0;
      frames_d     = '0;
      bytes_d      = '0;
      stall_d      = 1'b0;
      cur_valid_d  = 1'b0;
      cur_d        = '0;
      replayed_d   = '0;
      pend_cnt_d   = '0;
      pend_bytes_d = '0;
      pend_drop_d  = 1'b0;
      pend_first_d = 1'b1;
    end
    if (do_rst) begin
      rst_d    = 1'b1;
      serial_d = '0;
      // rest of an interrupted frame is dropped
      if (mid) begin
        pend_drop_d  = 1'b1;
        pend_first_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (state_q == S_FIN) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ring_head_q  <= '0;
      ring_used_q  <= '0;
      fifo_head_q  <= '0;
      fifo_used_q  <= '0;
      frames_q     <= '0;
      bytes_q      <= '0;
      stall_q      <= 1'b0;
      serial_q     <= '0;
      cur_valid_q  <= 1'b0;
      cur_q        <= '0;
      replayed_q   <= '0;
      pend_cnt_q   <= '0;
      pend_bytes_q <= '0;
      pend_drop_q  <= 1'b0;
      pend_first_q <= 1'b1;
      limit_q      <= LIMIT_W'(WINDOW_RESET * WINDOW_UNIT_BYTES);
      rdv_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ring_head_q  <= ring_head_d;
      ring_used_q  <= ring_used_d;
      fifo_head_q  <= fifo_head_d;
      fifo_used_q  <= fifo_used_d;
      frames_q     <= frames_d;
      bytes_q      <= bytes_d;
      stall_q      <= stall_d;
      serial_q     <= serial_d;
      cur_valid_q  <= cur_valid_d;
      cur_q        <= cur_d;
      replayed_q   <= replayed_d;
      pend_cnt_q   <= pend_cnt_d;
      pend_bytes_q <= pend_bytes_d;
      pend_drop_q  <= pend_drop_d;
      pend_first_q <= pend_first_d;
      rdv_q        <= rdv_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= LIMIT_W'(cfg_wdata_i) * LIMIT_W'(WINDOW_UNIT_BYTES);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= mode_i;
      len_q   <= payload_length_i;
      ctrl_q  <= is_control_i;
      hello_q <= is_hello_i;
      last_q  <= last_in_frame_i;
      ackv_q  <= ack_value_i;
      copy_q  <= copy_count_i;
    end
    rem_q     <= rem_d;
    off0_q    <= off0_d;
    popped_q  <= popped_d;
    tr_q      <= tr_d;
    pop_cnt_q <= pop_cnt_d;
    part_q    <= part_d;
    cnt_q     <= cnt_d;
    ok_q      <= ok_d;
    rst_q     <= rst_d;
    unst_q    <= unst_d;
    trimmed_q <= trimmed_d;
    if (state_q == S_FIN) begin
      out_ok_q      <= ok_q;
      out_rst_q     <= rst_q;
      out_stalled_q <= stall_q;
      out_unst_q    <= unst_q;
      out_trim_q    <= (32'(trimmed_q) > 32'(24'hFF_FFFF)) ? 24'hFF_FFFF : TRIM_W'(trimmed_q);
      out_bytes_q   <= (32'(bytes_q) > 32'(24'hFF_FFFF)) ? 24'hFF_FFFF : TRIM_W'(bytes_q);
      out_frames_q  <= (32'(frames_q) > 32'(9'h1FF)) ? 9'h1FF : FRAMES_W'(frames_q);
      out_serial_q  <= serial_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign ok_o                 = out_ok_q;
  assign session_reset_o      = out_rst_q;
  assign stalled_o            = out_stalled_q;
  assign unstalled_o          = out_unst_q;
  assign released_bytes_o     = out_trim_q;
  assign outstanding_frames_o = out_frames_q;
  assign outstanding_bytes_o  = out_bytes_q;
  assign last_ack_o           = out_serial_q;

endmodule

`default_nettype wire

// ===== design/uft_ram.sv =====
// simple dual port synchronous ram, registered read
`default_nettype none

module uft_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
